// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the k-th largest selector.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk while reset is released.
`define KLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, during reset as well.
`define KLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KLS_ASSERT(label, prop, msg)
`define KLS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/kls_pkg.sv
// Shared types and constants of the k-th largest selector.
// Depends on nothing; used by kls_cell and kth_largest_selector.
package kls_pkg;

    localparam int DATA_W         = 32;
    localparam int RANK_W         = 11;
    localparam int TOPK_DEPTH_DEF = 1024;
    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    // One incoming transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     set_end;
    } sample_t;

    // One outgoing transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] kth_value;
        logic                     result_valid;
    } result_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert;
        logic                     drain;
        logic signed [DATA_W-1:0] sample;
    } cell_ctrl_t;

endpackage

// File: rtl/kth_largest_selector.sv
// Top level of the k-th largest selector: a chain of compare-and-shift cells.
// An ordinary sample is in the chain in the next cycle; a set-ending sample with a valid result
// sets busy while the chain shifts, then strobes it; an invalid result is strobed in the next cycle.
// Throughput: one sample per cycle while busy is low; busy holds new samples off during a drain.
// Reset (rst_n, asynchronous, low): rank 1, store empty, no result; chain words are not reset.
// Results are strobed for one cycle and the receiver cannot stall them. Needs kls_pkg, kls_cell.
`include "assert_macros.svh"

module kth_largest_selector #(
    parameter int TOPK_DEPTH = kls_pkg::TOPK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  kls_pkg::sample_t            item,
    input  logic                        cfg_we,
    input  logic [kls_pkg::RANK_W-1:0]  cfg_wdata,
    output logic                        result_strobe,
    output kls_pkg::result_t            result
);
    import kls_pkg::*;

    // CNT_W holds a fill count up to the full depth, IDX_W a cell index and
    // CMP_W is wide enough to compare the rank with the depth.
    localparam int CNT_W = $clog2(TOPK_DEPTH + 1);
    localparam int IDX_W = (TOPK_DEPTH > 1) ? $clog2(TOPK_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t               state_reg,      state_next;
    logic [IDX_W-1:0]     drain_cnt_reg,  drain_cnt_next;
    logic [CNT_W-1:0]     held_count_reg, held_count_next;
    logic [RANK_W-1:0]    rank_reg,       rank_next;
    logic                 strobe_reg,     strobe_next;
    result_t              result_reg,     result_next;

    logic                 accept;
    logic [CMP_W-1:0]     rank_ext;
    logic [CMP_W-1:0]     depth_ext;
    logic [CMP_W-1:0]     limit_ext;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     count_eff;
    logic [CNT_W-1:0]     count_ins;
    logic                 rank_ok;
    cell_ctrl_t           ctrl;

    logic                     keep_w  [TOPK_DEPTH];
    logic signed [DATA_W-1:0] value_w [TOPK_DEPTH];

    // A transaction is taken whenever start is high and the block is not
    // draining the chain for a result.
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // The store never holds more than the current rank, nor more than the
    // chain has cells. When the rank shrinks within a set, the count is
    // clipped to the new limit before the next insertion is judged.
    assign rank_ext  = CMP_W'(rank_reg);
    assign depth_ext = CMP_W'(TOPK_DEPTH);
    assign limit_ext = (rank_ext > depth_ext) ? depth_ext : rank_ext;
    assign limit     = CNT_W'(limit_ext);
    assign count_eff = (held_count_reg > limit) ? limit : held_count_reg;

    always_comb
    begin
        if (limit == '0)
            count_ins = '0;
        else if (count_eff < limit)
            count_ins = count_eff + CNT_W'(1);
        else
            count_ins = count_eff;
    end

    // A result is only meaningful for a rank inside the chain and a set that
    // brought at least that many samples.
    assign rank_ok = (rank_ext != '0) && (rank_ext <= depth_ext)
                     && (CMP_W'(count_ins) >= rank_ext);

    // Every cell sees the same command. During the drain the chain moves one
    // place towards cell zero per cycle, so after rank_k - 1 steps the
    // wanted word sits in cell zero.
    assign ctrl.insert = accept;
    assign ctrl.drain  = (state_reg == ST_DRAIN) && (drain_cnt_reg != '0);
    assign ctrl.sample = item.sample_value;

    for (genvar i = 0; i < TOPK_DEPTH; i++)
    begin : g_cell
        logic                     prev_keep_w;
        logic signed [DATA_W-1:0] prev_value_w;
        logic signed [DATA_W-1:0] next_value_w;

        if (i == 0)
        begin : g_head
            assign prev_keep_w  = 1'b1;
            assign prev_value_w = '0;
        end
        else
        begin : g_body
            assign prev_keep_w  = keep_w[i-1];
            assign prev_value_w = value_w[i-1];
        end

        if (i == TOPK_DEPTH - 1)
        begin : g_tail
            assign next_value_w = value_w[i];
        end
        else
        begin : g_link
            assign next_value_w = value_w[i+1];
        end

        kls_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_eff),
            .prev_keep  (prev_keep_w),
            .prev_value (prev_value_w),
            .next_value (next_value_w),
            .keep       (keep_w[i]),
            .value      (value_w[i])
        );
    end

    // Control sequencing. A set-ending transaction either reports an invalid
    // result at once or starts the drain; the fill count is cleared either
    // way so that the next set starts empty.
    always_comb
    begin
        state_next      = state_reg;
        drain_cnt_next  = drain_cnt_reg;
        held_count_next = held_count_reg;
        rank_next       = rank_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        if (cfg_we)
            rank_next = cfg_wdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    held_count_next = count_ins;
                    if (item.set_end)
                    begin
                        held_count_next = '0;
                        if (rank_ok)
                        begin
                            state_next     = ST_DRAIN;
                            drain_cnt_next = IDX_W'(rank_ext - CMP_W'(1));
                        end
                        else
                        begin
                            strobe_next              = 1'b1;
                            result_next.kth_value    = '0;
                            result_next.result_valid = 1'b0;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_cnt_reg == '0)
                begin
                    state_next               = ST_IDLE;
                    strobe_next              = 1'b1;
                    result_next.kth_value    = value_w[0];
                    result_next.result_valid = 1'b1;
                end
                else
                begin
                    drain_cnt_next = drain_cnt_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            drain_cnt_reg  <= '0;
            held_count_reg <= '0;
            rank_reg       <= RANK_RESET;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            drain_cnt_reg  <= drain_cnt_next;
            held_count_reg <= held_count_next;
            rank_reg       <= rank_next;
            strobe_reg     <= strobe_next;
            result_reg     <= result_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // A result only follows a set-ending transaction or the end of a drain.
    `KLS_ASSERT(a_strobe_source, strobe_reg |-> ($past(accept && item.set_end) || $past(state_reg == ST_DRAIN)), "result strobe without a cause")
    // The fill count never exceeds the number of cells.
    `KLS_ASSERT(a_count_bound, held_count_reg <= CNT_W'(TOPK_DEPTH), "fill count beyond chain depth")
    // The store is already empty for the next set while the chain drains.
    `KLS_ASSERT(a_drain_empty, busy |-> (held_count_reg == '0), "fill count not cleared during drain")
    // An invalid result carries a zero value.
    `KLS_ASSERT(a_invalid_zero, (strobe_reg && !result_reg.result_valid) |-> (result_reg.kth_value == '0), "invalid result with non-zero value")
    // The drain counter steps down by one on every shift.
    `KLS_ASSERT(a_drain_step, ((state_reg == ST_DRAIN) && (drain_cnt_reg != '0)) |=> ((state_reg == ST_DRAIN) && (drain_cnt_reg == $past(drain_cnt_reg) - IDX_W'(1))), "drain counter out of step")

endmodule

// File: rtl/kls_cell.sv
// One compare-and-shift cell of the sorted chain.
// Depends on kls_pkg.
module kls_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 11
) (
    input  logic                             clk,
    input  kls_pkg::cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                 count,
    input  logic                             prev_keep,
    input  logic signed [kls_pkg::DATA_W-1:0] prev_value,
    input  logic signed [kls_pkg::DATA_W-1:0] next_value,
    output logic                             keep,
    output logic signed [kls_pkg::DATA_W-1:0] value
);
    import kls_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // The cell keeps its word when it is occupied and not smaller than the
    // new sample, so an equal sample lands behind it.
    assign keep  = (CNT_W'(INDEX) < count) && (value_reg >= ctrl.sample);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (keep)
                value_next = value_reg;
            else if (prev_keep)
                value_next = ctrl.sample;
            else
                value_next = prev_value;
        end
        else if (ctrl.drain)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
